// ----- src/delta_list_timer_queue_core_defines.svh -----
// Assertion macros shared by the timer queue RTL.
`ifndef DELTA_LIST_TIMER_QUEUE_CORE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define DLTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dltq assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define DLTQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dltq assertion failed");

`endif

// ----- src/dltq_pkg.sv -----
// Package: types, codes and helpers of the delta-list timer queue.
`default_nettype none
package dltq_pkg;
   localparam int CAPACITY_DEF = 32;
   localparam int WIDE_W = 40;
   localparam int MAX_FIRE = 32;
   localparam int CNT_W = $clog2(MAX_FIRE + 1);

   localparam logic [1:0] REQ_SCHED  = 2'd0;
   localparam logic [1:0] REQ_ADV    = 2'd1;
   localparam logic [1:0] REQ_CANCEL = 2'd2;

   localparam logic [1:0] RSP_SCHED  = 2'd0;
   localparam logic [1:0] RSP_FIRE   = 2'd1;
   localparam logic [1:0] RSP_CANCEL = 2'd2;
   localparam logic [1:0] RSP_FULL   = 2'd3;

   typedef enum logic [17:0] {
      ST_IDLE    = 18'd1,
      ST_S_START = 18'd2,
      ST_S_POP   = 18'd4,
      ST_S_RD    = 18'd8,
      ST_S_CMP   = 18'd16,
      ST_S_FIN1  = 18'd32,
      ST_S_FIN2  = 18'd64,
      ST_A_RD    = 18'd128,
      ST_A_UPD   = 18'd256,
      ST_F_RD    = 18'd512,
      ST_F_POP   = 18'd1024,
      ST_F_NXT   = 18'd2048,
      ST_C_RD    = 18'd4096,
      ST_C_CMP   = 18'd8192,
      ST_C_FIX   = 18'd16384,
      ST_C_LINK  = 18'd32768,
      ST_C_REL   = 18'd65536,
      ST_EMIT    = 18'd131072
   } step_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] req_type;
      logic       free_nil;
      logic       head_nil;
      logic       cur_nil;
      logic       nx_nil;
      logic       stop;
      logic       match;
      logic       upd_pos;
      logic       res_last;
      logic       out_free;
   } status_type;

   function automatic logic signed [WIDE_W-1:0] ext32_fn(input logic signed [31:0] v);
      return {{(WIDE_W - 32){v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32_fn(input logic signed [WIDE_W-1:0] v);
      if (v > ext32_fn(32'sh7FFFFFFF)) begin
         return 32'sh7FFFFFFF;
      end else if (v < ext32_fn(32'sh80000000)) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction
endpackage
`default_nettype wire

// ----- src/dltq_if.sv -----
// Request and response channel interfaces of the timer queue.
`default_nettype none
interface dltq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [15:0]        owner_id;
   logic [15:0]        function_id;
   logic signed [31:0] delay_ticks;
   logic [31:0]        argument;
   logic [30:0]        now_time;
   modport source (output valid, req_type, owner_id, function_id, delay_ticks, argument,
                   now_time, input ready);
   modport sink (input valid, req_type, owner_id, function_id, delay_ticks, argument,
                 now_time, output ready);
endinterface

interface dltq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  resp_kind;
   logic [15:0] out_owner;
   logic [15:0] out_function;
   logic [31:0] out_argument;
   logic [30:0] time_left;
   logic        was_found;
   logic        last_result;
   modport source (output valid, resp_kind, out_owner, out_function, out_argument, time_left,
                   was_found, last_result, input ready);
   modport sink (input valid, resp_kind, out_owner, out_function, out_argument, time_left,
                 was_found, last_result, output ready);
endinterface
`default_nettype wire

// ----- src/dltq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dltq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- src/dltq_ctrl.sv -----
// Controller state machine of the timer queue.
`default_nettype none
module dltq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dltq_pkg::status_type   status,
   output dltq_pkg::cmd_type           cmd
);
   import dltq_pkg::*;

   step_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               case (status.req_type)
                  REQ_SCHED:  state_in = ST_S_START;
                  REQ_ADV:    state_in = ST_A_RD;
                  REQ_CANCEL: state_in = ST_C_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_S_START: state_in = status.free_nil ? ST_EMIT : ST_S_POP;
         ST_S_POP:   state_in = ST_S_RD;
         ST_S_RD:    state_in = status.cur_nil ? ST_S_FIN1 : ST_S_CMP;
         ST_S_CMP:   state_in = status.stop ? ST_S_FIN1 : ST_S_RD;
         ST_S_FIN1:  state_in = ST_S_FIN2;
         ST_S_FIN2:  state_in = ST_EMIT;
         ST_A_RD:    state_in = status.head_nil ? ST_IDLE : ST_A_UPD;
         ST_A_UPD:   state_in = status.upd_pos ? ST_IDLE : ST_F_RD;
         ST_F_RD:    state_in = ST_F_POP;
         ST_F_POP:   state_in = status.nx_nil ? ST_EMIT : ST_F_NXT;
         ST_F_NXT:   state_in = ST_EMIT;
         ST_C_RD:    state_in = status.cur_nil ? ST_EMIT : ST_C_CMP;
         ST_C_CMP: begin
            if (!status.match) begin
               state_in = ST_C_RD;
            end else begin
               state_in = status.nx_nil ? ST_C_LINK : ST_C_FIX;
            end
         end
         ST_C_FIX:   state_in = ST_C_LINK;
         ST_C_LINK:  state_in = ST_C_REL;
         ST_C_REL:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.res_last ? ST_IDLE : ST_F_RD;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.step = state_ff;
endmodule
`default_nettype wire

// ----- src/dltq_datapath.sv -----
// Datapath of the timer queue: entry memories, list pointers, arithmetic, output register.
`default_nettype none
module dltq_datapath #(
   parameter int CAPACITY = dltq_pkg::CAPACITY_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dltq_pkg::cmd_type    cmd,
   output dltq_pkg::status_type      status,
   dltq_req_if.sink                  req_bus,
   dltq_rsp_if.source                rsp_bus
);
   import dltq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam logic [PW-1:0] NIL = PW'(CAPACITY);
   localparam logic signed [WIDE_W-1:0] TL_MAX = ext32_fn(32'sh7FFFFFFF);

   // list control
   logic [PW-1:0] head_ff, head_in, free_ff, free_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [PW-1:0] e_ff, e_in, nx_ff, nx_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [30:0] last_ff, last_in;
   logic [CAPACITY-1:0] lvld_ff, lvld_in;
   logic out_valid_ff, out_valid_in;
   logic res_last_ff, res_last_in;

   // working payload
   logic signed [WIDE_W-1:0] delay_ff, delay_in, sum_ff, sum_in;
   logic signed [31:0] dcur_ff, dcur_in, hd_ff, hd_in;
   logic [15:0] own_ff, own_in, fn_ff, fn_in;
   logic [31:0] arg_ff, arg_in;
   logic [30:0] now_ff, now_in;
   logic [1:0] res_kind_ff, res_kind_in;
   logic [63:0] res_pay_ff, res_pay_in;
   logic [30:0] res_left_ff, res_left_in;
   logic res_found_ff, res_found_in;
   logic [IW-1:0] lrd_idx_ff;

   // memory ports
   logic d_we, l_we, p_we;
   logic [IW-1:0] d_waddr, l_waddr, p_waddr, d_raddr, l_raddr, p_raddr;
   logic signed [31:0] d_wdata;
   logic [31:0] d_rdata;
   logic [PW-1:0] l_wdata, l_rdata, link_rd;
   logic [63:0] p_wdata, p_rdata;

   logic accept, out_free;
   logic signed [31:0] d_rd, nd_a, nd_f;
   logic signed [WIDE_W-1:0] d_ext, elapsed;

   dltq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_delta_ram (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(d_raddr), .rdata_ff(d_rdata)
   );
   dltq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_ram (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata_ff(l_rdata)
   );
   dltq_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_pay_ram (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata_ff(p_rdata)
   );

   assign req_bus.ready = (cmd.step == ST_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign out_free = !out_valid_ff || rsp_bus.ready;

   // unwritten links read as the reset free chain
   assign link_rd = lvld_ff[lrd_idx_ff] ? l_rdata :
                    ((lrd_idx_ff == IW'(CAPACITY - 1)) ? NIL : (PW'(lrd_idx_ff) + PW'(1)));
   assign d_rd = d_rdata;
   assign d_ext = ext32_fn(d_rd);
   assign elapsed = (last_ff == 31'd0) ? '0 :
                    (WIDE_W'(now_ff) - WIDE_W'(last_ff));
   assign nd_a = sat32_fn(d_ext - elapsed);
   assign nd_f = (hd_ff < 0) ? sat32_fn(d_ext + ext32_fn(hd_ff)) : d_rd;

   always_comb begin
      status.req_valid = req_bus.valid;
      status.req_type  = req_bus.req_type;
      status.free_nil  = (free_ff == NIL);
      status.head_nil  = (head_ff == NIL);
      status.cur_nil   = (cur_ff == NIL);
      status.nx_nil    = (link_rd == NIL);
      status.stop      = (d_ext >= delay_ff);
      status.match     = (p_rdata[63:48] == own_ff) && (p_rdata[47:32] == fn_ff);
      status.upd_pos   = (nd_a > 0);
      status.res_last  = res_last_ff;
      status.out_free  = out_free;
   end

   always_comb begin
      head_in = head_ff; free_in = free_ff; cur_in = cur_ff; prev_in = prev_ff;
      e_in = e_ff; nx_in = nx_ff; n_in = n_ff; last_in = last_ff; lvld_in = lvld_ff;
      out_valid_in = out_valid_ff; res_last_in = res_last_ff;
      delay_in = delay_ff; sum_in = sum_ff; dcur_in = dcur_ff; hd_in = hd_ff;
      own_in = own_ff; fn_in = fn_ff; arg_in = arg_ff; now_in = now_ff;
      res_kind_in = res_kind_ff; res_pay_in = res_pay_ff; res_left_in = res_left_ff;
      res_found_in = res_found_ff;
      d_we = 1'b0; d_waddr = cur_ff[IW-1:0]; d_wdata = d_rd;
      l_we = 1'b0; l_waddr = cur_ff[IW-1:0]; l_wdata = free_ff;
      p_we = 1'b0; p_waddr = free_ff[IW-1:0]; p_wdata = {own_ff, fn_ff, arg_ff};
      d_raddr = cur_ff[IW-1:0]; l_raddr = cur_ff[IW-1:0]; p_raddr = cur_ff[IW-1:0];

      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (cmd.step)
         ST_IDLE: begin
            if (accept) begin
               own_in = req_bus.owner_id;
               fn_in = req_bus.function_id;
               arg_in = req_bus.argument;
               now_in = req_bus.now_time;
               delay_in = req_bus.delay_ticks[31] ? '0 : ext32_fn(req_bus.delay_ticks);
               cur_in = head_ff;
               prev_in = NIL;
               sum_in = '0;
               n_in = '0;
            end
         end
         ST_S_START: begin
            l_raddr = free_ff[IW-1:0];
            res_kind_in = RSP_FULL; res_pay_in = '0; res_left_in = '0;
            res_found_in = 1'b0; res_last_in = 1'b1;
         end
         ST_S_POP: begin
            e_in = free_ff;
            free_in = link_rd;
            p_we = 1'b1;
         end
         ST_S_RD: ;
         ST_S_CMP: begin
            if (status.stop) begin
               d_we = 1'b1;
               d_wdata = sat32_fn(d_ext - delay_ff);
            end else begin
               delay_in = delay_ff - d_ext;
               prev_in = cur_ff;
               cur_in = link_rd;
            end
         end
         ST_S_FIN1: begin
            d_we = 1'b1; d_waddr = e_ff[IW-1:0]; d_wdata = sat32_fn(delay_ff);
            l_we = 1'b1; l_waddr = e_ff[IW-1:0]; l_wdata = cur_ff;
         end
         ST_S_FIN2: begin
            if (prev_ff != NIL) begin
               l_we = 1'b1; l_waddr = prev_ff[IW-1:0]; l_wdata = e_ff;
            end else begin
               head_in = e_ff;
            end
            res_kind_in = RSP_SCHED; res_pay_in = '0; res_left_in = '0;
            res_found_in = 1'b0; res_last_in = 1'b1;
         end
         ST_A_RD: begin
            d_raddr = head_ff[IW-1:0];
            if (status.head_nil) begin
               last_in = now_ff;
            end
         end
         ST_A_UPD: begin
            d_we = 1'b1; d_waddr = head_ff[IW-1:0]; d_wdata = nd_a;
            hd_in = nd_a;
            last_in = now_ff;
         end
         ST_F_RD: begin
            l_raddr = head_ff[IW-1:0];
            p_raddr = head_ff[IW-1:0];
         end
         ST_F_POP: begin
            l_we = 1'b1; l_waddr = head_ff[IW-1:0]; l_wdata = free_ff;
            free_in = head_ff;
            head_in = link_rd;
            d_raddr = link_rd[IW-1:0];
            res_kind_in = RSP_FIRE; res_pay_in = p_rdata; res_left_in = '0;
            res_found_in = 1'b0; res_last_in = (link_rd == NIL);
         end
         ST_F_NXT: begin
            d_we = 1'b1; d_waddr = head_ff[IW-1:0]; d_wdata = nd_f;
            hd_in = nd_f;
            res_last_in = (nd_f > 0) || (n_ff == CNT_W'(MAX_FIRE - 1));
         end
         ST_C_RD: begin
            res_kind_in = RSP_CANCEL; res_pay_in = '0; res_left_in = '0;
            res_found_in = 1'b0; res_last_in = 1'b1;
         end
         ST_C_CMP: begin
            sum_in = sum_ff + d_ext;
            if (status.match) begin
               nx_in = link_rd;
               dcur_in = d_rd;
               d_raddr = link_rd[IW-1:0];
            end else begin
               prev_in = cur_ff;
               cur_in = link_rd;
            end
         end
         ST_C_FIX: begin
            d_we = 1'b1; d_waddr = nx_ff[IW-1:0];
            d_wdata = sat32_fn(d_ext + ext32_fn(dcur_ff));
         end
         ST_C_LINK: begin
            if (prev_ff != NIL) begin
               l_we = 1'b1; l_waddr = prev_ff[IW-1:0]; l_wdata = nx_ff;
            end else begin
               head_in = nx_ff;
            end
         end
         ST_C_REL: begin
            l_we = 1'b1; l_waddr = cur_ff[IW-1:0]; l_wdata = free_ff;
            free_in = cur_ff;
            res_kind_in = RSP_CANCEL; res_pay_in = '0; res_found_in = 1'b1;
            res_last_in = 1'b1;
            if (sum_ff < 0) begin
               res_left_in = '0;
            end else if (sum_ff > TL_MAX) begin
               res_left_in = 31'h7FFFFFFF;
            end else begin
               res_left_in = sum_ff[30:0];
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               n_in = n_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase

      if (l_we) begin
         lvld_in[l_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL;
         free_ff <= '0;
         cur_ff <= NIL;
         prev_ff <= NIL;
         e_ff <= NIL;
         nx_ff <= NIL;
         n_ff <= '0;
         last_ff <= '0;
         lvld_ff <= '0;
         out_valid_ff <= 1'b0;
         res_last_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         free_ff <= free_in;
         cur_ff <= cur_in;
         prev_ff <= prev_in;
         e_ff <= e_in;
         nx_ff <= nx_in;
         n_ff <= n_in;
         last_ff <= last_in;
         lvld_ff <= lvld_in;
         out_valid_ff <= out_valid_in;
         res_last_ff <= res_last_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff <= delay_in;
      sum_ff <= sum_in;
      dcur_ff <= dcur_in;
      hd_ff <= hd_in;
      own_ff <= own_in;
      fn_ff <= fn_in;
      arg_ff <= arg_in;
      now_ff <= now_in;
      res_kind_ff <= res_kind_in;
      res_pay_ff <= res_pay_in;
      res_left_ff <= res_left_in;
      res_found_ff <= res_found_in;
      lrd_idx_ff <= l_raddr;
      if (cmd.step == ST_EMIT && out_free) begin
         rsp_bus.resp_kind <= res_kind_ff;
         rsp_bus.out_owner <= res_pay_ff[63:48];
         rsp_bus.out_function <= res_pay_ff[47:32];
         rsp_bus.out_argument <= res_pay_ff[31:0];
         rsp_bus.time_left <= res_left_ff;
         rsp_bus.was_found <= res_found_ff;
         rsp_bus.last_result <= res_last_ff;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
endmodule
`default_nettype wire

// ----- src/delta_list_timer_queue_core.sv -----
// Delta-list timer queue: pending callbacks sorted by due time in a fixed entry pool.
// req_bus carries one request per beat: schedule, advance (fire due entries) or cancel.
// rsp_bus returns the results of a request; last_result marks its final beat.
// Schedule answers one beat (scheduled, or rejected when the pool is full); cancel answers
// one beat with the time left and a found flag; advance returns one beat per fired entry
// (at most 32) or none. Unknown request types are taken and dropped.
// One request is worked at a time; req_bus.ready is high only while the sequencer is idle.
// Schedule: take a free entry, walk the list (a read and a compare per entry passed before
// the insert point), then write the new entry and link it in; a full pool skips to its beat.
// Cancel: walk the list with a read and a compare per entry up to the match, fix the next
// delta (skipped when the match is the tail), relink and release; a miss ends at the tail.
// Advance: read and update the head delta (nothing more on an empty queue or when nothing
// is due), then per fired entry a read, a pop and, unless it is the tail, a next-delta fix.
// The pace is set by the list walk: each hop reads the delta and link memories, whose
// read is registered, so the next address is known only once the read data is back.
// The result sits in an output register; while rsp_bus is stalled the sequencer waits at
// its next result, and a new request is taken as soon as the last result is registered.
// Reset (synchronous) empties the queue and rebuilds the free list at once through
// per-entry link valid bits; no clearing pass is needed.
`default_nettype none
`include "delta_list_timer_queue_core_defines.svh"
module delta_list_timer_queue_core #(
   parameter int CAPACITY = dltq_pkg::CAPACITY_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dltq_req_if.sink    req_bus,
   dltq_rsp_if.source  rsp_bus
);
   import dltq_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_taken;
   logic       emit_go;
   logic       rsp_single;

   dltq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .status(status), .cmd(cmd)
   );

   dltq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   assign req_taken = req_bus.valid && req_bus.ready && (req_bus.req_type <= REQ_CANCEL);
   assign emit_go = (cmd.step == ST_EMIT) && status.out_free;
   assign rsp_single = rsp_bus.valid && (rsp_bus.resp_kind != RSP_FIRE);

   `DLTQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_taken, !req_bus.ready)
   `DLTQ_ASSERT_NEXT(a_emit_loads, clock, reset, emit_go, rsp_bus.valid)
   `DLTQ_ASSERT_NOW(a_single_beat_last, clock, reset, rsp_single, rsp_bus.last_result)
endmodule
`default_nettype wire
